// File: hw/rtl/iqrt_pkg.sv
package iqrt_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned PIX_W   = 3 * CH_W;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 8;

  // largest image side; positions are POS_W bits, so it stays at 128
  localparam int unsigned MAX_DIM = 128;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_RED      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_GREEN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_BLUE     = 3'd5;

  // transaction opcodes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EMIT = 1'b1;

  // tint of 128 leaves a channel unchanged
  localparam logic [CH_W+1:0] TINT_BIAS = 10'd128;

  localparam logic [CH_W-1:0] DIM_RESET  = 8'd128;
  localparam logic [CH_W-1:0] TINT_RESET = 8'd128;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef struct packed {
    logic [CH_W-1:0] width;
    logic [CH_W-1:0] height;
    rot_e            rot;
    logic [CH_W-1:0] tint_r;
    logic [CH_W-1:0] tint_g;
    logic [CH_W-1:0] tint_b;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             last;
  } pos_t;

endpackage

// File: hw/rtl/image_quarter_rotate_tint.sv
// Frame-store image rotator with per-channel tint. A transaction with func_i = 0 writes the
// next source pixel into the frame store in raster order; one with func_i = 1 returns the
// next pixel of the output image, which is the source rotated by 0, 90, 180 or 270 degrees
// (width and height swap on quarter turns), each channel tinted as
// clamp(pixel + tint - 128, 0, 255). Both kinds of transaction are taken at one per cycle
// while the receiver keeps up: each uses the single port of the frame store exactly once,
// a load as one write, an emit as one read. An emit result passes from the frame store's
// read register to the output register; when that register and the read stage are both full,
// the input waits for the receiver. The frame store is not cleared after reset; reading a
// pixel that was never loaded returns undefined data. Configuration writes are meant to happen
// while the block is idle.
module image_quarter_rotate_tint (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [iqrt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [iqrt_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           func_i,
  input  logic [iqrt_pkg::CH_W-1:0]      in_red_i,
  input  logic [iqrt_pkg::CH_W-1:0]      in_green_i,
  input  logic [iqrt_pkg::CH_W-1:0]      in_blue_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [iqrt_pkg::CH_W-1:0]      out_red_o,
  output logic [iqrt_pkg::CH_W-1:0]      out_green_o,
  output logic [iqrt_pkg::CH_W-1:0]      out_blue_o,
  output logic [iqrt_pkg::POS_W-1:0]     out_x_o,
  output logic [iqrt_pkg::POS_W-1:0]     out_y_o,
  output logic                           last_pixel_o
);
  import iqrt_pkg::*;

  localparam int unsigned AW = $clog2(MAX_DIM * MAX_DIM);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= DIM_RESET;
      cfg_q.height <= DIM_RESET;
      cfg_q.rot    <= ROT_0;
      cfg_q.tint_r <= TINT_RESET;
      cfg_q.tint_g <= TINT_RESET;
      cfg_q.tint_b <= TINT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:   cfg_q.width  <= cfg_wdata_i;
        REG_IMAGE_HEIGHT:  cfg_q.height <= cfg_wdata_i;
        REG_ROTATION_MODE: cfg_q.rot    <= rot_e'(cfg_wdata_i[1:0]);
        REG_TINT_RED:      cfg_q.tint_r <= cfg_wdata_i;
        REG_TINT_GREEN:    cfg_q.tint_g <= cfg_wdata_i;
        REG_TINT_BLUE:     cfg_q.tint_b <= cfg_wdata_i;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  //   stage 1: frame store read in flight (data lands in the store's read reg)
  //   stage 2: output register
  // A load needs no downstream space but is held with emits to keep order simple.
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s1_adv;
  logic out_valid_q;
  logic in_fire, load_en, emit_en;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_en    = in_fire && (func_i == FUNC_LOAD);
  assign emit_en    = in_fire && (func_i == FUNC_EMIT);

  // ---------------------------------------------------------------------------
  // Address generation and frame store
  // ---------------------------------------------------------------------------
  logic [AW-1:0]    mem_addr;
  pos_t             pos;
  logic [PIX_W-1:0] rd_pix;

  iqrt_addr_gen #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_addr_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .load_en_i (load_en),
    .emit_en_i (emit_en),
    .addr_o    (mem_addr),
    .pos_o     (pos)
  );

  iqrt_frame_store #(
    .AW (AW)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (load_en),
    .re_i    (emit_en),
    .addr_i  (mem_addr),
    .wdata_i ({in_red_i, in_green_i, in_blue_i}),
    .rdata_o (rd_pix)
  );

  // position travels alongside the read
  pos_t s1_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (emit_en) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_en) begin
      s1_pos_q <= pos;
    end
  end

  // ---------------------------------------------------------------------------
  // Tint, then output register
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0] tint_r, tint_g, tint_b;

  iqrt_tint u_tint_r (
    .pix_i  (rd_pix[3*CH_W-1:2*CH_W]),
    .tint_i (cfg_q.tint_r),
    .pix_o  (tint_r)
  );

  iqrt_tint u_tint_g (
    .pix_i  (rd_pix[2*CH_W-1:CH_W]),
    .tint_i (cfg_q.tint_g),
    .pix_o  (tint_g)
  );

  iqrt_tint u_tint_b (
    .pix_i  (rd_pix[CH_W-1:0]),
    .tint_i (cfg_q.tint_b),
    .pix_o  (tint_b)
  );

  logic [CH_W-1:0] out_r_q, out_g_q, out_b_q;
  pos_t            out_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_r_q   <= tint_r;
      out_g_q   <= tint_g;
      out_b_q   <= tint_b;
      out_pos_q <= s1_pos_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_red_o    = out_r_q;
  assign out_green_o  = out_g_q;
  assign out_blue_o   = out_b_q;
  assign out_x_o      = out_pos_q.x;
  assign out_y_o      = out_pos_q.y;
  assign last_pixel_o = out_pos_q.last;

  // read data must hold while stage 1 waits on a full output register
  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> $stable(rd_pix))
    else $error("frame store read data changed under a stalled read");

  // no new transaction while stage 1 is blocked
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while pipeline stalled");

  // a waiting result holds until the receiver takes it
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_pos_q)))
    else $error("output transaction dropped or changed while waiting");

endmodule

// File: hw/rtl/iqrt_frame_store.sv
module iqrt_frame_store #(
  parameter int unsigned AW = 14
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              addr_i,
  input  logic [iqrt_pkg::PIX_W-1:0] wdata_i,
  output logic [iqrt_pkg::PIX_W-1:0] rdata_o
);
  import iqrt_pkg::*;

  localparam int unsigned DEPTH = 2 ** AW;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_q;

  // single port; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/iqrt_addr_gen.sv
module iqrt_addr_gen #(
  parameter int unsigned MAX_DIM = 128,
  parameter int unsigned AW      = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iqrt_pkg::cfg_t      cfg_i,
  input  logic                load_en_i,
  input  logic                emit_en_i,
  output logic [AW-1:0]       addr_o,
  output iqrt_pkg::pos_t      pos_o
);
  import iqrt_pkg::*;

  localparam int unsigned DW = $clog2(MAX_DIM + 1);
  localparam int unsigned CW = (DW > CH_W) ? DW : CH_W;
  localparam int unsigned TW = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int unsigned PW = 2 * DW;

  logic [CW-1:0] w_ext, h_ext;
  logic [DW-1:0] w_eff, h_eff;
  logic [PW-1:0] area;
  logic [TW-1:0] total;

  // clamp dimensions to 1..MAX_DIM
  always_comb begin
    w_ext = CW'(cfg_i.width);
    h_ext = CW'(cfg_i.height);
    if (w_ext == '0) begin
      w_eff = DW'(1);
    end else if (w_ext > CW'(MAX_DIM)) begin
      w_eff = DW'(MAX_DIM);
    end else begin
      w_eff = DW'(w_ext);
    end
    if (h_ext == '0) begin
      h_eff = DW'(1);
    end else if (h_ext > CW'(MAX_DIM)) begin
      h_eff = DW'(MAX_DIM);
    end else begin
      h_eff = DW'(h_ext);
    end
  end

  assign area  = PW'(w_eff) * PW'(h_eff);
  assign total = TW'(area);

  // load side
  logic [AW-1:0] load_cnt_q, load_cnt_d, load_base;
  logic [TW-1:0] load_inc;

  always_comb begin
    load_base  = (TW'(load_cnt_q) >= total) ? '0 : load_cnt_q;
    load_inc   = TW'(load_base) + TW'(1);
    load_cnt_d = (load_inc >= total) ? '0 : AW'(load_inc);
  end

  // emit side
  logic [DW-1:0] col_q, row_q, col_d, row_d;
  logic [DW-1:0] ow, oh, x, y, sx, sy;
  logic [PW-1:0] rd_full;
  logic          last;

  always_comb begin
    ow = cfg_i.rot[0] ? h_eff : w_eff;
    oh = cfg_i.rot[0] ? w_eff : h_eff;
    if (col_q >= ow || row_q >= oh) begin
      x = '0;
      y = '0;
    end else begin
      x = col_q;
      y = row_q;
    end
    case (cfg_i.rot)
      ROT_0: begin
        sx = x;
        sy = y;
      end
      ROT_90: begin
        sx = y;
        sy = h_eff - DW'(1) - x;
      end
      ROT_180: begin
        sx = w_eff - DW'(1) - x;
        sy = h_eff - DW'(1) - y;
      end
      default: begin
        sx = w_eff - DW'(1) - y;
        sy = x;
      end
    endcase
    rd_full = PW'(sy) * PW'(w_eff) + PW'(sx);
    last    = (x == ow - DW'(1)) && (y == oh - DW'(1));
    if (x == ow - DW'(1)) begin
      col_d = '0;
      row_d = (y == oh - DW'(1)) ? '0 : y + DW'(1);
    end else begin
      col_d = x + DW'(1);
      row_d = y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      if (load_en_i) begin
        load_cnt_q <= load_cnt_d;
      end
      if (emit_en_i) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  assign addr_o     = emit_en_i ? AW'(rd_full) : load_base;
  assign pos_o.x    = POS_W'(x);
  assign pos_o.y    = POS_W'(y);
  assign pos_o.last = last;

  a_load_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_en_i |=> (TW'(load_cnt_q) < $past(total)))
    else $error("load count left the frame");

  a_emit_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_en_i |=> (col_q < $past(ow)) && (row_q < $past(oh)))
    else $error("emit position left the output frame");

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_en_i && last) |=> (col_q == '0) && (row_q == '0))
    else $error("walk did not wrap after last pixel");

endmodule

// File: hw/rtl/iqrt_tint.sv
module iqrt_tint (
  input  logic [iqrt_pkg::CH_W-1:0] pix_i,
  input  logic [iqrt_pkg::CH_W-1:0] tint_i,
  output logic [iqrt_pkg::CH_W-1:0] pix_o
);
  import iqrt_pkg::*;

  logic [CH_W+1:0] sum;

  // pix + tint - 128, two's complement, clamped to 0..255
  always_comb begin
    sum = {2'b00, pix_i} + {2'b00, tint_i} - TINT_BIAS;
    if (sum[CH_W+1]) begin
      pix_o = '0;
    end else if (sum[CH_W]) begin
      pix_o = '1;
    end else begin
      pix_o = sum[CH_W-1:0];
    end
  end

endmodule

// File: tb/iqrt_frame_checker.sv
module iqrt_frame_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [iqrt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [iqrt_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           func_i,
  input  logic [iqrt_pkg::CH_W-1:0]      in_red_i,
  input  logic [iqrt_pkg::CH_W-1:0]      in_green_i,
  input  logic [iqrt_pkg::CH_W-1:0]      in_blue_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [iqrt_pkg::CH_W-1:0]      out_red_i,
  input  logic [iqrt_pkg::CH_W-1:0]      out_green_i,
  input  logic [iqrt_pkg::CH_W-1:0]      out_blue_i,
  input  logic [iqrt_pkg::POS_W-1:0]     out_x_i,
  input  logic [iqrt_pkg::POS_W-1:0]     out_y_i,
  input  logic                           last_pixel_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import iqrt_pkg::*;

  localparam int unsigned STORE_DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             last;
  } tinted_pixel_t;

  cfg_t             cfg;
  logic [PIX_W-1:0] frame_copy [STORE_DEPTH];
  int unsigned      load_addr;
  int unsigned      emit_col;
  int unsigned      emit_row;
  int unsigned      failures;
  tinted_pixel_t    expected_pixels [$];

  function automatic int unsigned clamp_dim(logic [CH_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // saturating add of the signed offset (tint - 128)
  function automatic logic [CH_W-1:0] apply_tint(logic [CH_W-1:0] p, logic [CH_W-1:0] t);
    int v;
    v = int'(p) + int'(t) - 128;
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return v[CH_W-1:0];
  endfunction

  task automatic note_failure(string msg);
    failures++;
    if (failures <= REPORT_LIMIT) $display("[%0t] %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    int unsigned   w, h, ow, oh, sx, sy;
    logic [PIX_W-1:0] px;
    tinted_pixel_t predicted, seen, oldest;
    if (!rst_ni) begin
      cfg = '{width: DIM_RESET, height: DIM_RESET, rot: ROT_0,
              tint_r: TINT_RESET, tint_g: TINT_RESET, tint_b: TINT_RESET};
      load_addr = 0;
      emit_col  = 0;
      emit_row  = 0;
      failures  = 0;
      expected_pixels.delete();
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      // results first: latency keeps a result apart from the transaction it came from
      if (out_valid_i && out_ready_i) begin
        seen = '{red: out_red_i, green: out_green_i, blue: out_blue_i,
                 x: out_x_i, y: out_y_i, last: last_pixel_i};
        if (expected_pixels.size() == 0) begin
          note_failure($sformatf("unexpected pixel rgb %h %h %h at (%0d,%0d) last %0b",
                                 seen.red, seen.green, seen.blue, seen.x, seen.y, seen.last));
        end else begin
          oldest = expected_pixels.pop_front();
          if (seen !== oldest) begin
            note_failure($sformatf({"pixel mismatch: expected rgb %h %h %h (%0d,%0d) last %0b,",
                                    " got rgb %h %h %h (%0d,%0d) last %0b"},
                                   oldest.red, oldest.green, oldest.blue, oldest.x, oldest.y,
                                   oldest.last, seen.red, seen.green, seen.blue, seen.x,
                                   seen.y, seen.last));
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_IMAGE_WIDTH:   cfg.width  = cfg_wdata_i;
          REG_IMAGE_HEIGHT:  cfg.height = cfg_wdata_i;
          REG_ROTATION_MODE: cfg.rot    = rot_e'(cfg_wdata_i[1:0]);
          REG_TINT_RED:      cfg.tint_r = cfg_wdata_i;
          REG_TINT_GREEN:    cfg.tint_g = cfg_wdata_i;
          REG_TINT_BLUE:     cfg.tint_b = cfg_wdata_i;
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        w = clamp_dim(cfg.width);
        h = clamp_dim(cfg.height);
        if (func_i == FUNC_LOAD) begin
          // restart when the frame shrank under the load pointer
          if (load_addr >= w * h) load_addr = 0;
          frame_copy[load_addr] = {in_red_i, in_green_i, in_blue_i};
          load_addr++;
          if (load_addr >= w * h) load_addr = 0;
        end else begin
          ow = cfg.rot[0] ? h : w;
          oh = cfg.rot[0] ? w : h;
          if (emit_col >= ow || emit_row >= oh) begin
            emit_col = 0;
            emit_row = 0;
          end
          case (cfg.rot)
            ROT_0:   begin sx = emit_col;         sy = emit_row;         end
            ROT_90:  begin sx = emit_row;         sy = h - 1 - emit_col; end
            ROT_180: begin sx = w - 1 - emit_col; sy = h - 1 - emit_row; end
            default: begin sx = w - 1 - emit_row; sy = emit_col;         end
          endcase
          px = frame_copy[sy * w + sx];
          predicted.red   = apply_tint(px[3*CH_W-1:2*CH_W], cfg.tint_r);
          predicted.green = apply_tint(px[2*CH_W-1:CH_W], cfg.tint_g);
          predicted.blue  = apply_tint(px[CH_W-1:0], cfg.tint_b);
          predicted.x     = emit_col[POS_W-1:0];
          predicted.y     = emit_row[POS_W-1:0];
          predicted.last  = (emit_col == ow - 1) && (emit_row == oh - 1);
          expected_pixels = {expected_pixels, predicted};
          emit_col++;
          if (emit_col >= ow) begin
            emit_col = 0;
            emit_row++;
            if (emit_row >= oh) emit_row = 0;
          end
        end
      end

      mismatch_count_o <= failures;
      pending_count_o  <= expected_pixels.size();
    end
  end

endmodule

// File: tb/tb_image_quarter_rotate_tint.sv
module tb_image_quarter_rotate_tint;
  timeunit 1ns;
  timeprecision 1ps;

  import iqrt_pkg::*;

  localparam int unsigned CLK_HALF        = 4;
  localparam int unsigned RESET_CYCLES    = 4;
  // random images stop once this many input transactions went out
  localparam int unsigned ITEM_TARGET     = 440;
  // output register sits behind the frame store's read register; leave some margin
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  // indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic                 func_i      = FUNC_LOAD;
  logic [CH_W-1:0]      in_red_i    = '0;
  logic [CH_W-1:0]      in_green_i  = '0;
  logic [CH_W-1:0]      in_blue_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [CH_W-1:0]      out_red_o;
  logic [CH_W-1:0]      out_green_o;
  logic [CH_W-1:0]      out_blue_o;
  logic [POS_W-1:0]     out_x_o;
  logic [POS_W-1:0]     out_y_o;
  logic                 last_pixel_o;

  int unsigned mismatch_count;
  int unsigned pending_pixels;
  int unsigned cycle_count     = 0;
  int unsigned items_sent      = 0;
  int unsigned burst_left      = 0;
  int unsigned hold_off_asked  = 0;
  int unsigned hold_off_served = 0;
  bit          steady          = 1'b0;

  image_quarter_rotate_tint uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .in_red_i     (in_red_i),
    .in_green_i   (in_green_i),
    .in_blue_i    (in_blue_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .last_pixel_o (last_pixel_o)
  );

  // Predicts every emit transaction and compares results in order.
  iqrt_frame_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .func_i           (func_i),
    .in_red_i         (in_red_i),
    .in_green_i       (in_green_i),
    .in_blue_i        (in_blue_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_red_i        (out_red_o),
    .out_green_i      (out_green_o),
    .out_blue_i       (out_blue_o),
    .out_x_i          (out_x_o),
    .out_y_i          (out_y_o),
    .last_pixel_i     (last_pixel_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_pixels)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_image_quarter_rotate_tint NOT OK");
      $finish;
    end
  end

  // Byte with a bias toward the saturation edges of the tint math.
  function automatic logic [CH_W-1:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      4:       return 8'h81;
      5:       return 8'h01;
      default: return 8'($urandom());
    endcase
  endfunction

  // Pixels in one source frame, with out-of-range register values clamped.
  function automatic int unsigned frame_pixels(logic [CH_W-1:0] w, logic [CH_W-1:0] h);
    int unsigned wd, ht;
    wd = (w == 0) ? 1 : (w > MAX_DIM) ? MAX_DIM : w;
    ht = (h == 0) ? 1 : (h > MAX_DIM) ? MAX_DIM : h;
    return wd * ht;
  endfunction

  // One input transaction. Valid rises at a clock edge and holds until accepted;
  // after a burst runs out, valid may drop for a random gap.
  task automatic offer_pixel(input logic fn, input logic [CH_W-1:0] r,
                             input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
    int unsigned gap;
    in_valid_i <= 1'b1;
    func_i     <= fn;
    in_red_i   <= r;
    in_green_i <= g;
    in_blue_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Drop valid and wait until every emitted pixel is back, then let loads drain.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Full register set while idle; the rotation word carries random upper bits,
  // and both unmapped indexes get junk that must be dropped.
  task automatic set_up_image(input logic [CH_W-1:0] w, input logic [CH_W-1:0] h,
                              input rot_e rot, input logic [CH_W-1:0] tint_r,
                              input logic [CH_W-1:0] tint_g, input logic [CH_W-1:0] tint_b);
    wait_idle();
    write_register(REG_IMAGE_WIDTH, w);
    write_register(REG_IMAGE_HEIGHT, h);
    write_register(REG_ROTATION_MODE, {6'($urandom()), rot});
    write_register(REG_TINT_RED, tint_r);
    write_register(REG_TINT_GREEN, tint_g);
    write_register(REG_TINT_BLUE, tint_b);
    write_register(REG_SPARE_A, 8'($urandom()));
    write_register(REG_SPARE_B, 8'($urandom()));
    cfg_we_i <= 1'b0;
  endtask

  // One image: configure, optionally fill a whole frame so that every entry an
  // emit can read has been written, then a mix of emits and overwriting loads.
  task automatic run_image(input logic [CH_W-1:0] w, input logic [CH_W-1:0] h,
                           input rot_e rot, input logic [CH_W-1:0] tint_r,
                           input logic [CH_W-1:0] tint_g, input logic [CH_W-1:0] tint_b,
                           input bit reload, input int unsigned extra,
                           input int unsigned emit_pct, input bit hold_off);
    set_up_image(w, h, rot, tint_r, tint_g, tint_b);
    steady = ($urandom_range(0, 3) == 0);
    if (reload) begin
      repeat (frame_pixels(w, h)) offer_pixel(FUNC_LOAD, pick_byte(), pick_byte(), pick_byte());
    end
    // receiver goes quiet while the emits keep coming, so the pipe backs up
    if (hold_off) hold_off_asked++;
    repeat (extra) begin
      offer_pixel(($urandom_range(1, 100) <= emit_pct) ? FUNC_EMIT : FUNC_LOAD,
                  pick_byte(), pick_byte(), pick_byte());
    end
  endtask

  // Receiver: segments of random length, each with its own stall rate
  // (free-flowing segments included), plus the requested long hold-offs.
  initial begin : receiver
    int unsigned seg_len, stall_pct;
    @(posedge clk_i);
    forever begin
      if (hold_off_served < hold_off_asked) begin
        hold_off_served++;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        seg_len = $urandom_range(1, 64);
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 30;
          3:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
        repeat (seg_len) begin
          out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_no, total, emit_pct;
    logic [CH_W-1:0] w_reg, h_reg;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 2x3 source, quarter turn -> 3x2 output. Red tint 0 floors, green tint 255
    // saturates high, blue passes through. Seven emits: full frame plus wrap.
    set_up_image(8'd2, 8'd3, ROT_90, 8'd0, 8'd255, 8'd128);
    offer_pixel(FUNC_LOAD, 8'h00, 8'h00, 8'h00);
    offer_pixel(FUNC_LOAD, 8'hFF, 8'hFF, 8'hFF);
    offer_pixel(FUNC_LOAD, 8'h80, 8'h7F, 8'h01);
    offer_pixel(FUNC_LOAD, 8'hFE, 8'h01, 8'h80);
    offer_pixel(FUNC_LOAD, 8'hAA, 8'h55, 8'h0F);
    offer_pixel(FUNC_LOAD, 8'h01, 8'hFE, 8'h7F);
    repeat (7) offer_pixel(FUNC_EMIT, pick_byte(), pick_byte(), pick_byte());

    // Width register 0 acts as 1: a single pixel frame, three-quarter turn.
    // Loads and emits both wrap on every transaction here.
    set_up_image(8'd0, 8'd1, ROT_270, 8'd1, 8'd254, 8'd127);
    offer_pixel(FUNC_LOAD, 8'h3C, 8'hC3, 8'h99);
    offer_pixel(FUNC_EMIT, 8'hFF, 8'hFF, 8'hFF);
    offer_pixel(FUNC_EMIT, 8'h00, 8'h00, 8'h00);
    offer_pixel(FUNC_LOAD, 8'hFF, 8'h00, 8'h80);
    offer_pixel(FUNC_EMIT, 8'h5A, 8'hA5, 8'h3C);

    // Random images. The first phase is the wide-frame pair: full 128-pixel
    // row, walked straight and then as a column (register 255 clamps to 128).
    // The rest are mostly tiny frames; leftover load and emit positions from
    // one image carry into the next, hitting the restart cases when the
    // frame shrinks.
    phase_no = 0;
    while (items_sent < ITEM_TARGET || phase_no < 2) begin
      if (phase_no == 0) begin
        run_image(8'd128, 8'd0, ROT_0, pick_byte(), pick_byte(), pick_byte(),
                  1'b1, 132, 100, 1'b1);
        run_image(8'd255, 8'd0, ROT_90, pick_byte(), pick_byte(), pick_byte(),
                  1'b0, 130, 100, 1'b0);
      end else begin
        w_reg = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 9));
        h_reg = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 9));
        total = frame_pixels(w_reg, h_reg);
        case ($urandom_range(0, 2))
          0:       emit_pct = 30;
          1:       emit_pct = 65;
          default: emit_pct = 95;
        endcase
        run_image(w_reg, h_reg, rot_e'($urandom_range(0, 3)),
                  pick_byte(), pick_byte(), pick_byte(),
                  1'b1, $urandom_range(total, 2 * total + 6), emit_pct, 1'b0);
      end
      phase_no++;
    end

    // drain outstanding pixels, then give the pipeline time to show strays
    wait_idle();
    if (mismatch_count == 0 && pending_pixels == 0) begin
      $display("tb_image_quarter_rotate_tint OK");
    end else begin
      $display("tb_image_quarter_rotate_tint NOT OK");
    end
    $finish;
  end

endmodule

// File: image_quarter_rotate_tint.f
hw/rtl/iqrt_pkg.sv
hw/rtl/iqrt_frame_store.sv
hw/rtl/iqrt_addr_gen.sv
hw/rtl/iqrt_tint.sv
hw/rtl/image_quarter_rotate_tint.sv
tb/iqrt_frame_checker.sv
tb/tb_image_quarter_rotate_tint.sv
